// ===== rtl/rmdf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rmdf_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int WINDOW_LEN_DEF   = 5;
  localparam int NUM_CHANNELS_DEF = 4;

  // Deadband register reset value in dB.
  localparam logic [6:0] DEADBAND_RESET = 7'd2;

  // ASCII codes that bound the accepted digit characters.
  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] ASCII_NINE = 8'd57;

  // Weight of the tens digit.
  localparam logic [6:0] TENS_WEIGHT = 7'd10;

  // A signed dBm sample as it sits in a window.
  typedef logic signed [7:0] sample_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ASCII_ZERO) && (c <= ASCII_NINE);
  endfunction

  function automatic logic [3:0] digit_val(input logic [7:0] c);
    logic [7:0] d;
    d = c - ASCII_ZERO;
    return d[3:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rmdf_median.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Rank-select median: every sample counts the samples that sort ahead of it
// (larger, or equal with a lower index). The sample with rank WINDOW_LEN/2
// is the median of the window.
module rmdf_median #(
  parameter int WINDOW_LEN = rmdf_pkg::WINDOW_LEN_DEF
) (
  input  rmdf_pkg::sample_t win_i [WINDOW_LEN],
  output rmdf_pkg::sample_t median_o
);

  localparam int RANK_W = $clog2(WINDOW_LEN);
  localparam logic [RANK_W-1:0] MID = RANK_W'(WINDOW_LEN / 2);

  logic [RANK_W-1:0] rank [WINDOW_LEN];

  always_comb begin
    for (int i = 0; i < WINDOW_LEN; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW_LEN; j++) begin
        if ((win_i[j] > win_i[i]) || ((j < i) && (win_i[j] == win_i[i]))) begin
          rank[i] = rank[i] + 1'b1;
        end
      end
    end
  end

  always_comb begin
    median_o = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      if (rank[i] == MID) begin
        median_o = win_i[i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rssi_median_deadband_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted transaction moves from the input register to the result register.
// Throughput: one transaction per cycle unless out_ready stalls the result
// register; per-channel state is read and written between the two registers.
// Reset (rst_n low, synchronous): windows, write slots, first-sample flags and
// held values clear to zero, the deadband returns to 2 dB, both stages empty.

module rssi_median_deadband_filter #(
  parameter int WINDOW_LEN   = rmdf_pkg::WINDOW_LEN_DEF,
  parameter int NUM_CHANNELS = rmdf_pkg::NUM_CHANNELS_DEF
) (
  input  wire                     clk,
  input  wire                     rst_n,
  // Input transaction channel.
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire  [1:0]              in_channel,
  input  wire  [7:0]              in_tx_tens_char,
  input  wire  [7:0]              in_tx_ones_char,
  input  wire  [7:0]              in_rssi_tens_char,
  input  wire  [7:0]              in_rssi_ones_char,
  // Result transaction channel.
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic [1:0]              out_channel_out,
  output logic signed [7:0]       out_tx_power,
  output logic signed [7:0]       out_rssi_held,
  output logic signed [7:0]       out_rssi_median,
  output logic                    out_updated,
  output logic                    out_bad_digit,
  // Deadband register write channel.
  input  wire                     cfg_valid,
  output logic                    cfg_ready,
  input  wire  [6:0]              cfg_deadband
);

  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SLOT_W = $clog2(WINDOW_LEN);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_LEN - 1);

  // ---------------------------------------------------------------------------
  // Configuration. The register may be written at any time; the user must issue
  // writes only while the block is idle (unenforced) so no transaction sees change.
  // ---------------------------------------------------------------------------
  logic [6:0] deadband_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r <= rmdf_pkg::DEADBAND_RESET;
    end else if (cfg_valid) begin
      deadband_r <= cfg_deadband;
    end
  end

  // ---------------------------------------------------------------------------
  // Input register. It refills in the same cycle that its item moves on to the
  // result register, so back-to-back transactions flow without bubbles.
  // ---------------------------------------------------------------------------
  logic       s1_valid_r;
  logic [1:0] s1_channel_r;
  logic [7:0] s1_tx_tens_r;
  logic [7:0] s1_tx_ones_r;
  logic [7:0] s1_rssi_tens_r;
  logic [7:0] s1_rssi_ones_r;
  logic       advance;
  logic       in_fire;

  assign advance  = s1_valid_r && (!out_valid || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_channel_r   <= in_channel;
      s1_tx_tens_r   <= in_tx_tens_char;
      s1_tx_ones_r   <= in_tx_ones_char;
      s1_rssi_tens_r <= in_rssi_tens_char;
      s1_rssi_ones_r <= in_rssi_ones_char;
    end
  end

  // ---------------------------------------------------------------------------
  // Per-channel state. It is updated at the same edge as the result register,
  // so the next item of the same channel already sees the new window.
  // ---------------------------------------------------------------------------
  rmdf_pkg::sample_t win_r  [NUM_CHANNELS][WINDOW_LEN];
  logic [SLOT_W-1:0] slot_r [NUM_CHANNELS];
  logic              seen_r [NUM_CHANNELS];
  rmdf_pkg::sample_t held_r [NUM_CHANNELS];

  // Channel decode. The channel port is two bits wide; values at or above the
  // channel count are rejected.
  logic [CH_W+1:0] ch_wide;
  logic [CH_W-1:0] ch_idx;
  logic            ch_ok;

  assign ch_wide = (CH_W + 2)'(s1_channel_r);
  assign ch_idx  = ch_wide[CH_W-1:0];
  assign ch_ok   = ch_wide < (CH_W + 2)'(NUM_CHANNELS);

  // Digit parsing: magnitude = 10 * tens + ones, then negated.
  logic              digits_ok;
  logic [6:0]        tx_mag;
  logic [6:0]        rssi_mag;
  rmdf_pkg::sample_t tx_val;
  rmdf_pkg::sample_t rssi_val;

  assign digits_ok = rmdf_pkg::is_digit(s1_tx_tens_r) && rmdf_pkg::is_digit(s1_tx_ones_r)
                  && rmdf_pkg::is_digit(s1_rssi_tens_r) && rmdf_pkg::is_digit(s1_rssi_ones_r);

  assign tx_mag   = 7'(rmdf_pkg::digit_val(s1_tx_tens_r)) * rmdf_pkg::TENS_WEIGHT
                  + 7'(rmdf_pkg::digit_val(s1_tx_ones_r));
  assign rssi_mag = 7'(rmdf_pkg::digit_val(s1_rssi_tens_r)) * rmdf_pkg::TENS_WEIGHT
                  + 7'(rmdf_pkg::digit_val(s1_rssi_ones_r));
  assign tx_val   = -rmdf_pkg::sample_t'({1'b0, tx_mag});
  assign rssi_val = -rmdf_pkg::sample_t'({1'b0, rssi_mag});

  // The selected channel's window with the new sample dropped into its slot.
  rmdf_pkg::sample_t win_new [WINDOW_LEN];
  logic [SLOT_W-1:0] slot_cur;
  logic [SLOT_W-1:0] slot_nxt;
  rmdf_pkg::sample_t held_cur;
  logic              seen_cur;

  assign slot_cur = slot_r[ch_idx];
  assign held_cur = held_r[ch_idx];
  assign seen_cur = seen_r[ch_idx];
  assign slot_nxt = (slot_cur == SLOT_LAST) ? '0 : slot_cur + 1'b1;

  always_comb begin
    for (int k = 0; k < WINDOW_LEN; k++) begin
      win_new[k] = (slot_cur == SLOT_W'(k)) ? rssi_val : win_r[ch_idx][k];
    end
  end

  rmdf_pkg::sample_t median;

  rmdf_median #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_median (
    .win_i    (win_new),
    .median_o (median)
  );

  // Deadband decision: the held value follows the median on the first sample
  // of a channel, and afterwards only when the change exceeds the deadband.
  logic signed [8:0] diff;
  logic [8:0]        diff_abs;
  logic              accept_ok;
  logic              upd;

  assign diff      = {median[7], median} - {held_cur[7], held_cur};
  assign diff_abs  = diff[8] ? 9'(-diff) : 9'(diff);
  assign accept_ok = ch_ok && digits_ok;
  assign upd       = accept_ok && (!seen_cur || (diff_abs > {2'b00, deadband_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        slot_r[c] <= '0;
        seen_r[c] <= 1'b0;
        held_r[c] <= '0;
        for (int k = 0; k < WINDOW_LEN; k++) begin
          win_r[c][k] <= '0;
        end
      end
    end else if (advance && accept_ok) begin
      slot_r[ch_idx] <= slot_nxt;
      seen_r[ch_idx] <= 1'b1;
      win_r[ch_idx][slot_cur] <= rssi_val;
      if (upd) begin
        held_r[ch_idx] <= median;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register. A rejected transaction reports zero tx power and median,
  // and a held value that is the channel's current one if it exists, else zero.
  // ---------------------------------------------------------------------------
  logic              out_valid_r;
  rmdf_pkg::sample_t res_tx;
  rmdf_pkg::sample_t res_held;
  rmdf_pkg::sample_t res_median;

  always_comb begin
    if (accept_ok) begin
      res_tx     = tx_val;
      res_median = median;
      res_held   = upd ? median : held_cur;
    end else begin
      res_tx     = '0;
      res_median = '0;
      res_held   = ch_ok ? held_cur : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_channel_out <= s1_channel_r;
      out_tx_power    <= res_tx;
      out_rssi_held   <= res_held;
      out_rssi_median <= res_median;
      out_updated     <= upd;
      out_bad_digit   <= !accept_ok;
    end
  end

  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_bad_not_updated : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_bad_digit && out_updated))
    else $error("rejected transaction reported an update");

  a_update_takes_median : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_updated) |-> (out_rssi_held == out_rssi_median))
    else $error("updated held value differs from the median");

  a_stage_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_channel_r)))
    else $error("input register lost a stalled transaction");

  a_ready_when_drained : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled while the result register is empty");

  a_slot_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && ch_ok |-> (slot_cur <= SLOT_LAST))
    else $error("ring write slot beyond the window");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  // Sizes follow the defaults that the block itself is built with.
  localparam int WIN   = rmdf_pkg::WINDOW_LEN_DEF;
  localparam int CHANS = rmdf_pkg::NUM_CHANNELS_DEF;

  // The limit lies far above any correct run, so this only trips on a hang.
  localparam int CYCLE_LIMIT      = 200000;
  localparam int MAX_REPORTS      = 10;
  localparam int LONG_HOLD_CYCLES = 150;
  localparam int MAX_IDLE         = 16;

  // One beacon sample as offered on the input channel.
  typedef struct packed {
    logic [1:0] channel;
    logic [7:0] tx_tens;
    logic [7:0] tx_ones;
    logic [7:0] rssi_tens;
    logic [7:0] rssi_ones;
  } beacon_item_t;

  // One filter answer as seen on the result channel.
  typedef struct packed {
    logic [1:0]        channel;
    rmdf_pkg::sample_t tx_power;
    rmdf_pkg::sample_t rssi_held;
    rmdf_pkg::sample_t rssi_median;
    logic              updated;
    logic              bad_digit;
  } filter_result_t;

  logic       clk;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_ready;
  logic [1:0] in_channel   = '0;
  logic [7:0] in_tx_tens_char   = '0;
  logic [7:0] in_tx_ones_char   = '0;
  logic [7:0] in_rssi_tens_char = '0;
  logic [7:0] in_rssi_ones_char = '0;
  logic       out_valid;
  logic       out_ready    = 1'b0;
  logic [1:0] out_channel_out;
  logic signed [7:0] out_tx_power;
  logic signed [7:0] out_rssi_held;
  logic signed [7:0] out_rssi_median;
  logic       out_updated;
  logic       out_bad_digit;
  logic       cfg_valid    = 1'b0;
  logic       cfg_ready;
  logic [6:0] cfg_deadband = '0;

  rssi_median_deadband_filter dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_channel        (in_channel),
    .in_tx_tens_char   (in_tx_tens_char),
    .in_tx_ones_char   (in_tx_ones_char),
    .in_rssi_tens_char (in_rssi_tens_char),
    .in_rssi_ones_char (in_rssi_ones_char),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_channel_out   (out_channel_out),
    .out_tx_power      (out_tx_power),
    .out_rssi_held     (out_rssi_held),
    .out_rssi_median   (out_rssi_median),
    .out_updated       (out_updated),
    .out_bad_digit     (out_bad_digit),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_deadband      (cfg_deadband)
  );

  // Samples waiting to be offered, and filter answers waiting to come back.
  beacon_item_t   pending_items[$];
  filter_result_t expected_results[$];

  // Our own copy of the per-channel filter state and of the deadband register.
  rmdf_pkg::sample_t win_samples [CHANS][WIN];
  int unsigned       win_slot    [CHANS];
  logic              chan_seen   [CHANS];
  rmdf_pkg::sample_t chan_held   [CHANS];
  logic [6:0]        deadband_model;

  // Handshake flags seen at the last rising edge; the falling-edge drivers read them.
  bit in_fire;
  bit out_fire;

  // Idling controls, set per phase by the stimulus process.
  bit send_idle;
  bit recv_idle;
  int hold_requests;
  int hold_served;
  int hold_left;
  int send_gap;
  int recv_wait;

  int unsigned mismatches;
  int unsigned cycle_count;

  // Last RSSI magnitude per channel, so random samples can wander near it and
  // exercise the deadband rather than always jumping far.
  int rssi_track [CHANS];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic ascii_digit_ok(input logic [7:0] c);
    return (c >= rmdf_pkg::ASCII_ZERO) && (c <= rmdf_pkg::ASCII_NINE);
  endfunction

  function automatic int char_val(input logic [7:0] c);
    return int'(c) - int'(rmdf_pkg::ASCII_ZERO);
  endfunction

  // Works out the answer for one accepted sample and advances the model state.
  // A sample with a non-digit character leaves every piece of state alone.
  function automatic filter_result_t filter_sample(input beacon_item_t it);
    filter_result_t    r;
    rmdf_pkg::sample_t vals [WIN];
    rmdf_pkg::sample_t key;
    rmdf_pkg::sample_t rssi;
    rmdf_pkg::sample_t med;
    int                ch;
    int                j;
    int                k;
    int                diff;
    logic              upd;
    ch          = int'(it.channel);
    r           = '0;
    r.channel   = it.channel;
    r.bad_digit = 1'b1;
    if (ch >= CHANS) return r;
    if (!(ascii_digit_ok(it.tx_tens) && ascii_digit_ok(it.tx_ones) &&
          ascii_digit_ok(it.rssi_tens) && ascii_digit_ok(it.rssi_ones))) begin
      r.rssi_held = chan_held[ch];
      return r;
    end
    r.tx_power = rmdf_pkg::sample_t'(-(char_val(it.tx_tens) * 10 + char_val(it.tx_ones)));
    rssi       = rmdf_pkg::sample_t'(-(char_val(it.rssi_tens) * 10 + char_val(it.rssi_ones)));

    // Ring write: the oldest entry is replaced, never reordered.
    win_samples[ch][win_slot[ch]] = rssi;
    win_slot[ch] = (win_slot[ch] + 1 >= WIN) ? 0 : win_slot[ch] + 1;

    // Median over a sorted copy; unwritten entries count as 0 dBm.
    for (j = 0; j < WIN; j++) vals[j] = win_samples[ch][j];
    for (j = 1; j < WIN; j++) begin
      key = vals[j];
      k   = j - 1;
      while (k >= 0 && vals[k] > key) begin
        vals[k + 1] = vals[k];
        k--;
      end
      vals[k + 1] = key;
    end
    med = vals[WIN / 2];

    // The first sample of a channel always loads the held value; afterwards the
    // median must move strictly further than the deadband.
    upd = 1'b0;
    if (!chan_seen[ch]) begin
      chan_seen[ch] = 1'b1;
      upd = 1'b1;
    end else begin
      diff = int'(med) - int'(chan_held[ch]);
      if (diff < 0) diff = -diff;
      if (diff > int'(deadband_model)) upd = 1'b1;
    end
    if (upd) chan_held[ch] = med;

    r.rssi_held   = chan_held[ch];
    r.rssi_median = med;
    r.updated     = upd;
    r.bad_digit   = 1'b0;
    return r;
  endfunction

  function automatic beacon_item_t digits_item(input int ch, input int tx_mag,
                                               input int rssi_mag);
    beacon_item_t it;
    it.channel   = 2'(ch);
    it.tx_tens   = rmdf_pkg::ASCII_ZERO + 8'(tx_mag / 10);
    it.tx_ones   = rmdf_pkg::ASCII_ZERO + 8'(tx_mag % 10);
    it.rssi_tens = rmdf_pkg::ASCII_ZERO + 8'(rssi_mag / 10);
    it.rssi_ones = rmdf_pkg::ASCII_ZERO + 8'(rssi_mag % 10);
    return it;
  endfunction

  task automatic queue_digits(input int ch, input int tx_mag, input int rssi_mag);
    pending_items.push_back(digits_item(ch, tx_mag, rssi_mag));
  endtask

  task automatic queue_raw(input int ch, input logic [7:0] tt, input logic [7:0] to,
                           input logic [7:0] rt, input logic [7:0] ro);
    beacon_item_t it;
    it = '{channel: 2'(ch), tx_tens: tt, tx_ones: to, rssi_tens: rt, rssi_ones: ro};
    pending_items.push_back(it);
  endtask

  // Mostly well-formed samples whose RSSI drifts near the channel's last value,
  // some uniform jumps, and some noise with garbage characters.
  task automatic queue_random(input int count);
    beacon_item_t it;
    int           n;
    int           ch;
    int           sel;
    int           mag;
    for (n = 0; n < count; n++) begin
      ch  = $urandom_range(0, CHANS - 1);
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        mag = rssi_track[ch] + int'($urandom_range(0, 8)) - 4;
        if (mag < 0) mag = 0;
        if (mag > 99) mag = 99;
      end else begin
        mag = $urandom_range(0, 99);
      end
      if (sel < 85) rssi_track[ch] = mag;
      it = digits_item(ch, $urandom_range(0, 99), mag);
      if (sel >= 85) begin
        if ($urandom_range(0, 2) == 0) begin
          it.tx_tens   = 8'($urandom);
          it.tx_ones   = 8'($urandom);
          it.rssi_tens = 8'($urandom);
          it.rssi_ones = 8'($urandom);
        end else begin
          case ($urandom_range(0, 3))
            0:       it.tx_tens   = 8'($urandom);
            1:       it.tx_ones   = 8'($urandom);
            2:       it.rssi_tens = 8'($urandom);
            default: it.rssi_ones = 8'($urandom);
          endcase
        end
      end
      pending_items.push_back(it);
    end
  endtask

  // The register is only written while nothing is in flight, so the model can
  // take the new value at the accepting edge.
  task automatic write_deadband(input logic [6:0] value);
    @(negedge clk);
    cfg_valid    <= 1'b1;
    cfg_deadband <= value;
    do @(posedge clk); while (!cfg_ready);
    deadband_model = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every sample has been taken and answered, then lets the
  // pipeline settle a little longer.
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Sender: presents one sample at a time and holds it until it is taken.
  // After each transaction it draws the idle gap before the next one.
  always @(negedge clk) begin
    beacon_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // The current sample has not been taken yet, so it stays on the bus.
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid <= 1'b0;
    end else if (pending_items.size() != 0) begin
      it = pending_items.pop_front();
      in_channel        <= it.channel;
      in_tx_tens_char   <= it.tx_tens;
      in_tx_ones_char   <= it.tx_ones;
      in_rssi_tens_char <= it.rssi_tens;
      in_rssi_ones_char <= it.rssi_ones;
      in_valid          <= 1'b1;
      send_gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: stalls a random number of cycles after each result, and on
  // request holds off for a long stretch so the block backs up into its input.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        hold_left   = LONG_HOLD_CYCLES;
      end
      if (out_fire) recv_wait = recv_idle ? $urandom_range(0, MAX_IDLE) : 0;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: checks every result transaction against the oldest expectation and
  // turns every accepted input transaction into a new expectation. Both sides
  // are sampled at the rising edge, before the block's own registers move.
  always @(posedge clk) begin
    filter_result_t got;
    filter_result_t want;
    beacon_item_t   taken;
    in_fire  = 1'b0;
    out_fire = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        out_fire        = 1'b1;
        got.channel     = out_channel_out;
        got.tx_power    = out_tx_power;
        got.rssi_held   = out_rssi_held;
        got.rssi_median = out_rssi_median;
        got.updated     = out_updated;
        got.bad_digit   = out_bad_digit;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result ch=%0d tx=%0d held=%0d med=%0d upd=%0b bad=%0b",
                     $realtime, got.channel, got.tx_power, got.rssi_held,
                     got.rssi_median, got.updated, got.bad_digit);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t: mismatch exp ch=%0d tx=%0d held=%0d med=%0d upd=%0b bad=%0b",
                       $realtime, want.channel, want.tx_power, want.rssi_held,
                       want.rssi_median, want.updated, want.bad_digit);
              $display("%0t:          got ch=%0d tx=%0d held=%0d med=%0d upd=%0b bad=%0b",
                       $realtime, got.channel, got.tx_power, got.rssi_held,
                       got.rssi_median, got.updated, got.bad_digit);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        in_fire = 1'b1;
        taken   = '{channel: in_channel, tx_tens: in_tx_tens_char,
                    tx_ones: in_tx_ones_char, rssi_tens: in_rssi_tens_char,
                    rssi_ones: in_rssi_ones_char};
        expected_results.push_back(filter_sample(taken));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int c;
    int s;
    for (c = 0; c < CHANS; c++) begin
      for (s = 0; s < WIN; s++) win_samples[c][s] = '0;
      win_slot[c]   = 0;
      chan_seen[c]  = 1'b0;
      chan_held[c]  = '0;
      rssi_track[c] = $urandom_range(30, 80);
    end
    deadband_model = rmdf_pkg::DEADBAND_RESET;
    send_idle = 1'b1;
    recv_idle = 1'b1;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, with the deadband still at its reset value.
    // First sample of a channel at 0 dBm: the held value already equals the
    // median, yet the update flag must still be raised.
    queue_digits(0, 0, 0);
    // Largest magnitudes; with one sample the unwritten zeros carry the median.
    queue_digits(1, 99, 99);
    // More of the same so the ring wraps past its end.
    for (c = 0; c < 5; c++) queue_digits(1, 9 + c * 20, 99);
    queue_digits(1, 90, 10);
    // Non-digit characters just outside the digit range, and at the byte
    // extremes, in each of the four positions; a rejected sample on a channel
    // that has never been loaded reports zero, one on a loaded channel its held value.
    queue_raw(2, 8'd47, "5", "5", "5");
    queue_raw(2, "5", 8'd58, "5", "5");
    queue_raw(3, "5", "5", 8'h00, "5");
    queue_raw(3, "5", "5", "5", 8'hFF);
    queue_raw(1, 8'hFF, 8'h00, 8'd58, 8'd47);
    // A steady level, then drifts of exactly the deadband (held stays) and of
    // one more than the deadband (held follows).
    queue_digits(2, 40, 50);
    queue_digits(2, 40, 50);
    queue_digits(2, 40, 50);
    queue_digits(2, 40, 52);
    queue_digits(2, 40, 52);
    queue_digits(2, 40, 53);
    queue_digits(2, 40, 53);
    queue_digits(2, 40, 53);
    wait_drained();

    // Random phases, each at its own deadband and idling mix.
    write_deadband(7'd0);
    queue_random(80);
    wait_drained();

    write_deadband(7'd127);
    send_idle = 1'b0;
    queue_random(80);
    wait_drained();

    // The receiver goes quiet while the sender streams back to back, so the
    // result register fills and the input must stall. Idling returns once the
    // long hold has run out.
    write_deadband(7'($urandom_range(0, 127)));
    recv_idle = 1'b0;
    hold_requests++;
    queue_random(60);
    wait (hold_served == hold_requests && hold_left == 0);
    recv_idle = 1'b1;
    send_idle = 1'b1;
    queue_random(20);
    wait_drained();

    write_deadband(7'd1);
    recv_idle = 1'b0;
    queue_random(80);
    wait_drained();

    // A stretch with no idling on either side.
    write_deadband(7'($urandom_range(0, 127)));
    send_idle = 1'b0;
    queue_random(80);
    wait_drained();

    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== rssi_median_deadband_filter.f =====
rtl/rmdf_pkg.sv
rtl/rmdf_median.sv
rtl/rssi_median_deadband_filter.sv
bench/testbench.sv
